/* rtl/core/osat_pkg.sv */
// Shared constants, types and codes of the oriented box overlap test.
package osat_pkg;

    // Sine polynomial, Q.18 coefficients, and fixed-point units
    localparam logic [18:0] POLY_A    = 19'd411773;
    localparam logic [17:0] POLY_B    = 18'd168188;
    localparam logic [14:0] POLY_C    = 15'd18559;
    localparam logic [18:0] PHASE_ONE = 19'd262144;
    localparam logic [15:0] TRIG_ONE  = 16'd16384;

    // Pipeline depths of the units, and the number of axes
    localparam int TRIG_LAT   = 5;
    localparam int CORNER_LAT = 2;
    localparam int CELL_LAT   = 3;
    localparam int NUM_AXES   = 4;

    // Corner sign masks: bit i set means the corner takes minus that half extent
    localparam logic [3:0] CORNER_NEG_X = 4'b1001;
    localparam logic [3:0] CORNER_NEG_Y = 4'b0011;

    // Axis codes, in test order
    localparam int AXIS_A_X = 0;
    localparam int AXIS_A_Y = 1;
    localparam int AXIS_B_X = 2;
    localparam int AXIS_B_Y = 3;

    // Trig bundle slots
    localparam int TRIG_CA = 0;
    localparam int TRIG_SA = 1;
    localparam int TRIG_CB = 2;
    localparam int TRIG_SB = 3;

    typedef struct packed {
        logic sep;
        logic found;
    } osat_flags_t;

endpackage

/* rtl/core/osat_mulq14.sv */
// Registered multiply by a Q1.14 factor, rounded half away from zero.
module osat_mulq14 import osat_pkg::*;
#(
    parameter int W = 35
)
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] v,
    input  logic signed [15:0]  k,
    output logic signed [W-1:0] prod
);

    logic [W-1:0]    mag_v;
    logic [14:0]     mag_k;
    logic [W+14:0]   full;
    logic [W:0]      mag_r;
    logic            neg;
    logic signed [W-1:0] prod_next;
    logic signed [W-1:0] prod_reg;

    always_comb
    begin
        mag_v     = v[W-1] ? W'(-v) : W'(v);
        mag_k     = k[15] ? 15'(-k) : 15'(k);
        neg       = v[W-1] ^ k[15];
        full      = (W+15)'(mag_v) * (W+15)'(mag_k) + (W+15)'(8192);
        mag_r     = full[W+14:14];
        prod_next = neg ? W'(-mag_r) : W'(mag_r);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/osat_trig.sv */
// Pipelined Q1.14 sine of a binary angle, at most one multiply per stage.
module osat_trig import osat_pkg::*;
#(
    parameter int AW = 16
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [AW-1:0]       angle,
    output logic signed [15:0]  value
);

    logic [1:0]  quad;
    logic [18:0] t_raw;
    logic [18:0] t;

    logic [1:0]  quad1_reg, quad2_reg, quad3_reg, quad4_reg;
    logic [18:0] t1_reg, t2v_reg, t2_reg, t3_reg;
    logic [18:0] t2sq_reg;
    logic [17:0] mid_reg;
    logic [18:0] outer_reg;
    logic [18:0] s_reg;
    logic signed [15:0] value_reg;

    logic [18:0] t2sq_next;
    logic [14:0] inner;
    logic [17:0] mid_next;
    logic [18:0] mid2;
    logic [18:0] outer_next;
    logic [18:0] s_next;
    logic [15:0] r;
    logic [15:0] r_cap;

    always_comb
    begin
        quad      = angle[AW-1:AW-2];
        t_raw     = 19'(angle[AW-3:0]) << (20 - AW);
        t         = quad[0] ? PHASE_ONE - t_raw : t_raw;
        t2sq_next = 19'((38'(t) * 38'(t)) >> 18);
        inner     = 15'((34'(POLY_C) * 34'(t2sq_reg)) >> 18);
        mid_next  = POLY_B - 18'(inner);
        mid2      = 19'((37'(mid_reg) * 37'(t2v_reg)) >> 18);
        outer_next = POLY_A - mid2;
        s_next    = 19'((38'(outer_reg) * 38'(t3_reg)) >> 18);
        r         = 16'((20'(s_reg) + 20'd8) >> 4);
        r_cap     = (r > TRIG_ONE) ? TRIG_ONE : r;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad1_reg <= quad;
            t1_reg    <= t;
            t2sq_reg  <= t2sq_next;

            quad2_reg <= quad1_reg;
            t2_reg    <= t1_reg;
            t2v_reg   <= t2sq_reg;
            mid_reg   <= mid_next;

            quad3_reg <= quad2_reg;
            t3_reg    <= t2_reg;
            outer_reg <= outer_next;

            quad4_reg <= quad3_reg;
            s_reg     <= s_next;

            value_reg <= quad4_reg[1] ? -$signed(r_cap) : $signed(r_cap);
        end
    end

    assign value = value_reg;

endmodule

/* rtl/core/osat_corner.sv */
// Two-stage corner generator: rotate the half extents and offset by the centre.
module osat_corner import osat_pkg::*;
#(
    parameter int CW = 32
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [CW-2:0]        half_w,
    input  logic [CW-2:0]        half_h,
    input  logic signed [15:0]   c,
    input  logic signed [15:0]   s,
    input  logic signed [CW:0]   dx,
    input  logic signed [CW:0]   dy,
    output logic signed [CW+2:0] cx [4],
    output logic signed [CW+2:0] cy [4],
    output logic signed [15:0]   c_out,
    output logic signed [15:0]   s_out
);

    localparam int CRW = CW + 3;

    logic signed [CW-1:0] p_wc, p_hs, p_ws, p_hc;
    logic signed [CW:0]   dx_reg, dy_reg;
    logic signed [15:0]   c_reg, s_reg, c2_reg, s2_reg;
    logic signed [CRW-1:0] cx_next [4];
    logic signed [CRW-1:0] cy_next [4];
    logic signed [CRW-1:0] cx_reg [4];
    logic signed [CRW-1:0] cy_reg [4];

    osat_mulq14 #(.W(CW)) u_mul_wc (.clk(clk), .en(en), .v($signed({1'b0, half_w})), .k(c),
                                    .prod(p_wc));
    osat_mulq14 #(.W(CW)) u_mul_hs (.clk(clk), .en(en), .v($signed({1'b0, half_h})), .k(s),
                                    .prod(p_hs));
    osat_mulq14 #(.W(CW)) u_mul_ws (.clk(clk), .en(en), .v($signed({1'b0, half_w})), .k(s),
                                    .prod(p_ws));
    osat_mulq14 #(.W(CW)) u_mul_hc (.clk(clk), .en(en), .v($signed({1'b0, half_h})), .k(c),
                                    .prod(p_hc));

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cx_next[i] = CRW'(dx_reg)
                       + (CORNER_NEG_X[i] ? -CRW'(p_wc) : CRW'(p_wc))
                       - (CORNER_NEG_Y[i] ? -CRW'(p_hs) : CRW'(p_hs));
            cy_next[i] = CRW'(dy_reg)
                       + (CORNER_NEG_X[i] ? -CRW'(p_ws) : CRW'(p_ws))
                       + (CORNER_NEG_Y[i] ? -CRW'(p_hc) : CRW'(p_hc));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx;
            dy_reg <= dy;
            c_reg  <= c;
            s_reg  <= s;
            c2_reg <= c_reg;
            s2_reg <= s_reg;
            for (int i = 0; i < 4; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
            end
        end
    end

    assign cx    = cx_reg;
    assign cy    = cy_reg;
    assign c_out = c2_reg;
    assign s_out = s2_reg;

endmodule

/* rtl/core/osat_axis_cell.sv */
// One axis of the test: project all corners, overlap, fold into the running best.
module osat_axis_cell import osat_pkg::*;
#(
    parameter int CW    = 32,
    parameter int INDEX = 0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW+2:0] ax_in [4],
    input  logic signed [CW+2:0] ay_in [4],
    input  logic signed [CW+2:0] bx_in [4],
    input  logic signed [CW+2:0] by_in [4],
    input  logic signed [15:0]   trig_in [4],
    input  osat_flags_t          flags_in,
    input  logic signed [CW+4:0] best_in,
    input  logic signed [15:0]   nx_in,
    input  logic signed [15:0]   ny_in,
    output logic signed [CW+2:0] ax_out [4],
    output logic signed [CW+2:0] ay_out [4],
    output logic signed [CW+2:0] bx_out [4],
    output logic signed [CW+2:0] by_out [4],
    output logic signed [15:0]   trig_out [4],
    output osat_flags_t          flags_out,
    output logic signed [CW+4:0] best_out,
    output logic signed [15:0]   nx_out,
    output logic signed [15:0]   ny_out
);

    localparam int CRW = CW + 3;
    localparam int PW  = CW + 4;
    localparam int BW  = CW + 5;

    logic signed [15:0] axis_x, axis_y;

    logic signed [CRW-1:0] pax [4];
    logic signed [CRW-1:0] pay [4];
    logic signed [CRW-1:0] pbx [4];
    logic signed [CRW-1:0] pby [4];

    // corner and trig delay line, one slot per stage
    logic signed [CRW-1:0] ax_d [CELL_LAT][4];
    logic signed [CRW-1:0] ay_d [CELL_LAT][4];
    logic signed [CRW-1:0] bx_d [CELL_LAT][4];
    logic signed [CRW-1:0] by_d [CELL_LAT][4];
    logic signed [15:0]    trig_d [CELL_LAT][4];

    osat_flags_t         flags1_reg, flags2_reg, flags3_reg;
    logic signed [BW-1:0] best1_reg, best2_reg, best3_reg;
    logic signed [15:0]  nx1_reg, ny1_reg, nx2_reg, ny2_reg, nx3_reg, ny3_reg;
    logic signed [15:0]  axx1_reg, axy1_reg, axx2_reg, axy2_reg;

    logic signed [PW-1:0] pa [4];
    logic signed [PW-1:0] pb [4];
    logic signed [PW-1:0] a_lo_next, a_hi_next, b_lo_next, b_hi_next;
    logic signed [PW-1:0] a_lo_reg, a_hi_reg, b_lo_reg, b_hi_reg;

    logic signed [PW-1:0] hi_min, lo_max;
    logic signed [BW-1:0] pen;
    osat_flags_t          flags3_next;
    logic signed [BW-1:0] best3_next;
    logic signed [15:0]   nx3_next, ny3_next;

    always_comb
    begin
        case (INDEX)
            AXIS_A_X:
            begin
                axis_x = trig_in[TRIG_CA];
                axis_y = trig_in[TRIG_SA];
            end
            AXIS_A_Y:
            begin
                axis_x = -trig_in[TRIG_SA];
                axis_y = trig_in[TRIG_CA];
            end
            AXIS_B_X:
            begin
                axis_x = trig_in[TRIG_CB];
                axis_y = trig_in[TRIG_SB];
            end
            default:
            begin
                axis_x = -trig_in[TRIG_SB];
                axis_y = trig_in[TRIG_CB];
            end
        endcase
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_proj
        osat_mulq14 #(.W(CRW)) u_ax (.clk(clk), .en(en), .v(ax_in[i]), .k(axis_x), .prod(pax[i]));
        osat_mulq14 #(.W(CRW)) u_ay (.clk(clk), .en(en), .v(ay_in[i]), .k(axis_y), .prod(pay[i]));
        osat_mulq14 #(.W(CRW)) u_bx (.clk(clk), .en(en), .v(bx_in[i]), .k(axis_x), .prod(pbx[i]));
        osat_mulq14 #(.W(CRW)) u_by (.clk(clk), .en(en), .v(by_in[i]), .k(axis_y), .prod(pby[i]));
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pa[i] = PW'(pax[i]) + PW'(pay[i]);
            pb[i] = PW'(pbx[i]) + PW'(pby[i]);
        end
        a_lo_next = (pa[0] < pa[1]) ? pa[0] : pa[1];
        a_lo_next = (pa[2] < a_lo_next) ? pa[2] : a_lo_next;
        a_lo_next = (pa[3] < a_lo_next) ? pa[3] : a_lo_next;
        a_hi_next = (pa[0] > pa[1]) ? pa[0] : pa[1];
        a_hi_next = (pa[2] > a_hi_next) ? pa[2] : a_hi_next;
        a_hi_next = (pa[3] > a_hi_next) ? pa[3] : a_hi_next;
        b_lo_next = (pb[0] < pb[1]) ? pb[0] : pb[1];
        b_lo_next = (pb[2] < b_lo_next) ? pb[2] : b_lo_next;
        b_lo_next = (pb[3] < b_lo_next) ? pb[3] : b_lo_next;
        b_hi_next = (pb[0] > pb[1]) ? pb[0] : pb[1];
        b_hi_next = (pb[2] > b_hi_next) ? pb[2] : b_hi_next;
        b_hi_next = (pb[3] > b_hi_next) ? pb[3] : b_hi_next;
    end

    // fold this axis into the running result; drop everything once separated
    always_comb
    begin
        hi_min      = (a_hi_reg < b_hi_reg) ? a_hi_reg : b_hi_reg;
        lo_max      = (a_lo_reg > b_lo_reg) ? a_lo_reg : b_lo_reg;
        pen         = BW'(hi_min) - BW'(lo_max);
        flags3_next = flags2_reg;
        best3_next  = best2_reg;
        nx3_next    = nx2_reg;
        ny3_next    = ny2_reg;
        if (!flags2_reg.sep)
        begin
            if (pen <= 0)
            begin
                flags3_next.sep = 1'b1;
            end
            else if (!flags2_reg.found || pen < best2_reg)
            begin
                flags3_next.found = 1'b1;
                best3_next        = pen;
                nx3_next          = axx2_reg;
                ny3_next          = axy2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ax_d[0][i]   <= ax_in[i];
                ay_d[0][i]   <= ay_in[i];
                bx_d[0][i]   <= bx_in[i];
                by_d[0][i]   <= by_in[i];
                trig_d[0][i] <= trig_in[i];
                for (int j = 1; j < CELL_LAT; j++)
                begin
                    ax_d[j][i]   <= ax_d[j-1][i];
                    ay_d[j][i]   <= ay_d[j-1][i];
                    bx_d[j][i]   <= bx_d[j-1][i];
                    by_d[j][i]   <= by_d[j-1][i];
                    trig_d[j][i] <= trig_d[j-1][i];
                end
            end

            flags1_reg <= flags_in;
            best1_reg  <= best_in;
            nx1_reg    <= nx_in;
            ny1_reg    <= ny_in;
            axx1_reg   <= axis_x;
            axy1_reg   <= axis_y;

            flags2_reg <= flags1_reg;
            best2_reg  <= best1_reg;
            nx2_reg    <= nx1_reg;
            ny2_reg    <= ny1_reg;
            axx2_reg   <= axx1_reg;
            axy2_reg   <= axy1_reg;
            a_lo_reg   <= a_lo_next;
            a_hi_reg   <= a_hi_next;
            b_lo_reg   <= b_lo_next;
            b_hi_reg   <= b_hi_next;

            flags3_reg <= flags3_next;
            best3_reg  <= best3_next;
            nx3_reg    <= nx3_next;
            ny3_reg    <= ny3_next;
        end
    end

    assign ax_out    = ax_d[CELL_LAT-1];
    assign ay_out    = ay_d[CELL_LAT-1];
    assign bx_out    = bx_d[CELL_LAT-1];
    assign by_out    = by_d[CELL_LAT-1];
    assign trig_out  = trig_d[CELL_LAT-1];
    assign flags_out = flags3_reg;
    assign best_out  = best3_reg;
    assign nx_out    = nx3_reg;
    assign ny_out    = ny3_reg;

endmodule

/* rtl/core/obb_separating_axis_test.sv */
// Top level of the oriented box separating-axis test: input stage, trig, corners, axis chain.
// Path from an accepted input item to its result item on the master side: the input
//   register loaded at the accepting edge, then 5 sine stages, 2 corner stages,
//   4 axis cells of 3 stages and 1 output register.
// Throughput: one item per cycle; every stage is a register and the whole pipe advances
//   together whenever the output register is empty or being taken.
// Reset: rst_n clears all valid bits at once; data registers are not reset.
module obb_separating_axis_test import osat_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // a_center_x, a_center_y, a_half_width, a_half_height, a_angle,
    // b_center_x, b_center_y, b_half_width, b_half_height, b_angle; zero padded
    input  logic [((2*(4*COORD_WIDTH-2+ANGLE_WIDTH)+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // penetration[31:0], normal_x[47:32], normal_y[63:48]
    output logic [63:0] m_tdata,
    // hit
    output logic [0:0]  m_tuser
);

    localparam int CW       = COORD_WIDTH;
    localparam int AW       = ANGLE_WIDTH;
    localparam int HW       = CW - 1;
    localparam int CRW      = CW + 3;
    localparam int BW       = CW + 5;
    localparam int BOX_BITS = 4*CW - 2 + AW;
    localparam int OFF_CX   = 0;
    localparam int OFF_CY   = CW;
    localparam int OFF_HW   = 2*CW;
    localparam int OFF_HH   = 3*CW - 1;
    localparam int OFF_ANG  = 4*CW - 2;
    localparam int LAT      = TRIG_LAT + CORNER_LAT + NUM_AXES*CELL_LAT;
    localparam logic [AW-1:0] QUARTER = AW'(1) << (AW - 2);

    logic en;

    // input stage
    logic                 v0_reg;
    logic signed [CW-1:0] acx_reg, acy_reg, bcx_reg, bcy_reg;
    logic [HW-1:0]        ahw_reg, ahh_reg, bhw_reg, bhh_reg;
    logic [AW-1:0]        aang_reg, bang_reg;
    logic signed [CW:0]   dx0, dy0;

    // payload riding alongside the sine pipes
    logic [HW-1:0]      ahw_d [TRIG_LAT];
    logic [HW-1:0]      ahh_d [TRIG_LAT];
    logic [HW-1:0]      bhw_d [TRIG_LAT];
    logic [HW-1:0]      bhh_d [TRIG_LAT];
    logic signed [CW:0] dx_d  [TRIG_LAT];
    logic signed [CW:0] dy_d  [TRIG_LAT];

    logic [LAT-1:0] vld_reg;

    logic signed [15:0] sa, ca, sb, cb;
    logic signed [15:0] ca2, sa2, cb2, sb2;

    logic signed [CRW-1:0] ax [NUM_AXES+1][4];
    logic signed [CRW-1:0] ay [NUM_AXES+1][4];
    logic signed [CRW-1:0] bx [NUM_AXES+1][4];
    logic signed [CRW-1:0] by [NUM_AXES+1][4];
    logic signed [15:0]    trig [NUM_AXES+1][4];
    osat_flags_t           flags [NUM_AXES+1];
    logic signed [BW-1:0]  best [NUM_AXES+1];
    logic signed [15:0]    nx [NUM_AXES+1];
    logic signed [15:0]    ny [NUM_AXES+1];

    logic        out_valid_reg;
    logic [63:0] out_data_reg, out_data_next;
    logic        out_hit_reg, out_hit_next;
    logic [63:0] best_wide;
    logic [31:0] pen_sat;

    // advance the whole pipe unless a finished item is stuck at the output
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign dx0 = (CW+1)'(bcx_reg) - (CW+1)'(acx_reg);
    assign dy0 = (CW+1)'(bcy_reg) - (CW+1)'(acy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= s_tvalid;
            vld_reg       <= {vld_reg[LAT-2:0], v0_reg};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acx_reg  <= $signed(s_tdata[OFF_CX +: CW]);
            acy_reg  <= $signed(s_tdata[OFF_CY +: CW]);
            ahw_reg  <= s_tdata[OFF_HW +: HW];
            ahh_reg  <= s_tdata[OFF_HH +: HW];
            aang_reg <= s_tdata[OFF_ANG +: AW];
            bcx_reg  <= $signed(s_tdata[BOX_BITS + OFF_CX +: CW]);
            bcy_reg  <= $signed(s_tdata[BOX_BITS + OFF_CY +: CW]);
            bhw_reg  <= s_tdata[BOX_BITS + OFF_HW +: HW];
            bhh_reg  <= s_tdata[BOX_BITS + OFF_HH +: HW];
            bang_reg <= s_tdata[BOX_BITS + OFF_ANG +: AW];

            ahw_d[0] <= ahw_reg;
            ahh_d[0] <= ahh_reg;
            bhw_d[0] <= bhw_reg;
            bhh_d[0] <= bhh_reg;
            dx_d[0]  <= dx0;
            dy_d[0]  <= dy0;
            for (int j = 1; j < TRIG_LAT; j++)
            begin
                ahw_d[j] <= ahw_d[j-1];
                ahh_d[j] <= ahh_d[j-1];
                bhw_d[j] <= bhw_d[j-1];
                bhh_d[j] <= bhh_d[j-1];
                dx_d[j]  <= dx_d[j-1];
                dy_d[j]  <= dy_d[j-1];
            end

            out_data_reg <= out_data_next;
            out_hit_reg  <= out_hit_next;
        end
    end

    // sine and cosine of both boxes; cosine is the sine a quarter turn ahead
    osat_trig #(.AW(AW)) u_sin_a (.clk(clk), .en(en), .angle(aang_reg), .value(sa));
    osat_trig #(.AW(AW)) u_cos_a (.clk(clk), .en(en), .angle(aang_reg + QUARTER), .value(ca));
    osat_trig #(.AW(AW)) u_sin_b (.clk(clk), .en(en), .angle(bang_reg), .value(sb));
    osat_trig #(.AW(AW)) u_cos_b (.clk(clk), .en(en), .angle(bang_reg + QUARTER), .value(cb));

    // box A corners sit around the origin; box B is shifted by the centre difference
    osat_corner #(.CW(CW)) u_corner_a
    (
        .clk    (clk),
        .en     (en),
        .half_w (ahw_d[TRIG_LAT-1]),
        .half_h (ahh_d[TRIG_LAT-1]),
        .c      (ca),
        .s      (sa),
        .dx     ('0),
        .dy     ('0),
        .cx     (ax[0]),
        .cy     (ay[0]),
        .c_out  (ca2),
        .s_out  (sa2)
    );

    osat_corner #(.CW(CW)) u_corner_b
    (
        .clk    (clk),
        .en     (en),
        .half_w (bhw_d[TRIG_LAT-1]),
        .half_h (bhh_d[TRIG_LAT-1]),
        .c      (cb),
        .s      (sb),
        .dx     (dx_d[TRIG_LAT-1]),
        .dy     (dy_d[TRIG_LAT-1]),
        .cx     (bx[0]),
        .cy     (by[0]),
        .c_out  (cb2),
        .s_out  (sb2)
    );

    assign trig[0][TRIG_CA] = ca2;
    assign trig[0][TRIG_SA] = sa2;
    assign trig[0][TRIG_CB] = cb2;
    assign trig[0][TRIG_SB] = sb2;
    assign flags[0]         = '0;
    assign best[0]          = '0;
    assign nx[0]            = '0;
    assign ny[0]            = '0;

    // axis chain: each cell tests one axis and hands the running best to the next
    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_axis
        osat_axis_cell #(.CW(CW), .INDEX(g)) u_cell
        (
            .clk       (clk),
            .en        (en),
            .ax_in     (ax[g]),
            .ay_in     (ay[g]),
            .bx_in     (bx[g]),
            .by_in     (by[g]),
            .trig_in   (trig[g]),
            .flags_in  (flags[g]),
            .best_in   (best[g]),
            .nx_in     (nx[g]),
            .ny_in     (ny[g]),
            .ax_out    (ax[g+1]),
            .ay_out    (ay[g+1]),
            .bx_out    (bx[g+1]),
            .by_out    (by[g+1]),
            .trig_out  (trig[g+1]),
            .flags_out (flags[g+1]),
            .best_out  (best[g+1]),
            .nx_out    (nx[g+1]),
            .ny_out    (ny[g+1])
        );
    end

    // hit only when no axis separated; zero every field otherwise; saturate penetration
    always_comb
    begin
        best_wide    = 64'(best[NUM_AXES]);
        pen_sat      = (best_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : best_wide[31:0];
        out_hit_next = flags[NUM_AXES].found && !flags[NUM_AXES].sep;
        if (out_hit_next)
        begin
            out_data_next = {ny[NUM_AXES], nx[NUM_AXES], pen_sat};
        end
        else
        begin
            out_data_next = '0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_hit_reg;

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
        else $error("miss item carries nonzero fields");

    a_hit_has_depth: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] != 32'd0)
        else $error("hit item with zero penetration");

    a_hit_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            $signed(m_tdata[47:32]) >= -16'sd16384 && $signed(m_tdata[47:32]) <= 16'sd16384 &&
            $signed(m_tdata[63:48]) >= -16'sd16384 && $signed(m_tdata[63:48]) <= 16'sd16384)
        else $error("normal outside unit range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v0_reg)
        else $error("accepted item lost at input stage");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

endmodule

/* tb/obb_separating_axis_test_test.sv */
// Testbench for the oriented box separating-axis test: random and directed box pairs.
module obb_separating_axis_test_test;

    localparam int CW = 32;
    localparam int AW = 16;
    localparam int DW = ((2*(4*CW-2+AW)+7)/8)*8;

    typedef struct {
        logic        hit;
        logic [31:0] penetration;
        logic [15:0] normal_x;
        logic [15:0] normal_y;
    } contact_t;

    typedef struct {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [30:0] hw;
        logic [30:0] hh;
        logic [15:0] ang;
    } box_t;

    // Integer sine in Q1.14 from a binary angle (polynomial in Q.18)
    function automatic int sine_q14(logic [15:0] ang);
        longint unsigned t, t2, inner, mid, mid2, outer, s, r;
        logic [1:0] quad;
        quad = ang[15:14];
        t = longint'(ang[13:0]) << 4;
        if (quad[0])
            t = 64'd262144 - t;
        t2 = (t * t) >> 18;
        inner = (64'd18559 * t2) >> 18;
        mid = 64'd168188 - inner;
        mid2 = (mid * t2) >> 18;
        outer = 64'd411773 - mid2;
        s = (outer * t) >> 18;
        r = (s + 8) >> 4;
        if (r > 16384)
            r = 16384;
        return quad[1] ? -int'(r) : int'(r);
    endfunction

    // Q.16 times Q1.14, rounded to nearest, halves away from zero
    function automatic longint scale_q14(longint v, int k);
        longint unsigned mv, mk, r;
        logic neg;
        neg = (v < 0) != (k < 0);
        mv = v < 0 ? -v : v;
        mk = k < 0 ? -k : k;
        r = (mv >> 14) * mk + (((mv & 64'h3FFF) * mk + 8192) >> 14);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic contact_t collide(box_t a, box_t b);
        contact_t res;
        int ca, sa, cb, sb, cs, sn;
        int nx[4], ny[4];
        longint px[8], py[8], dx, dy, lx, ly, best, p, lo0, hi0, lo1, hi1, pen;
        logic found, sep;
        ca = sine_q14(a.ang + 16'h4000); sa = sine_q14(a.ang);
        cb = sine_q14(b.ang + 16'h4000); sb = sine_q14(b.ang);
        nx[0] = ca;  ny[0] = sa;
        nx[1] = -sa; ny[1] = ca;
        nx[2] = cb;  ny[2] = sb;
        nx[3] = -sb; ny[3] = cb;
        for (int i = 0; i < 8; i++) begin
            if (i < 4) begin
                dx = 0; dy = 0; lx = a.hw; ly = a.hh; cs = ca; sn = sa;
            end else begin
                dx = longint'($signed(b.cx)) - longint'($signed(a.cx));
                dy = longint'($signed(b.cy)) - longint'($signed(a.cy));
                lx = b.hw; ly = b.hh; cs = cb; sn = sb;
            end
            // corner order: (-,-) (+,-) (+,+) (-,+)
            if ((i % 4) == 0 || (i % 4) == 3) lx = -lx;
            if ((i % 4) < 2) ly = -ly;
            px[i] = dx + scale_q14(lx, cs) - scale_q14(ly, sn);
            py[i] = dy + scale_q14(lx, sn) + scale_q14(ly, cs);
        end
        found = 0; sep = 0; best = 0;
        res = '{0, 0, 0, 0};
        for (int k = 0; k < 4 && !sep; k++) begin
            for (int i = 0; i < 8; i++) begin
                p = scale_q14(px[i], nx[k]) + scale_q14(py[i], ny[k]);
                if (i == 0) begin lo0 = p; hi0 = p; end
                else if (i == 4) begin lo1 = p; hi1 = p; end
                else if (i < 4) begin
                    if (p < lo0) lo0 = p;
                    if (p > hi0) hi0 = p;
                end else begin
                    if (p < lo1) lo1 = p;
                    if (p > hi1) hi1 = p;
                end
            end
            pen = (hi0 < hi1 ? hi0 : hi1) - (lo0 > lo1 ? lo0 : lo1);
            if (pen <= 0)
                sep = 1;
            else if (!found || pen < best) begin
                found = 1; best = pen;
                res.normal_x = nx[k][15:0];
                res.normal_y = ny[k][15:0];
            end
        end
        if (sep || !found)
            return '{0, 0, 0, 0};
        res.hit = 1;
        res.penetration = best > 64'hFFFFFFFF ? 32'hFFFFFFFF : best[31:0];
        return res;
    endfunction

    class contact_board;
        contact_t pending[$];
        int errors;

        function void note_pair(box_t a, box_t b);
            pending.push_back(collide(a, b));
        endfunction

        function void check_contact(contact_t got);
            contact_t want;
            if (pending.size() == 0) begin
                $error("result item with none pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
            end
            if (got.penetration !== want.penetration) begin
                $error("penetration: expected %h, got %h", want.penetration,
                       got.penetration);
                errors++;
            end
            if (got.normal_x !== want.normal_x) begin
                $error("normal_x: expected %h, got %h", want.normal_x, got.normal_x);
                errors++;
            end
            if (got.normal_y !== want.normal_y) begin
                $error("normal_y: expected %h, got %h", want.normal_y, got.normal_y);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [63:0]   m_tdata;
    logic [0:0]    m_tuser;

    contact_board board;
    int  send_idle;     // percent of cycles the sender idles
    int  recv_idle;     // percent of cycles the receiver stalls
    int  hold_cycles;   // long receiver hold-off, counted below
    logic hold_req;     // ask the receiver for one long hold-off
    logic hold_taken;   // the hold-off request has been served

    obb_separating_axis_test u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Random box with mostly small, nearby coordinates so that hits are common
    function automatic box_t rand_box();
        box_t b;
        int mode;
        mode = $urandom_range(0, 9);
        b.ang = 16'($urandom);
        if (mode < 7) begin
            b.cx = $signed($urandom_range(0, 32'h000C0000)) - 32'sh00060000;
            b.cy = $signed($urandom_range(0, 32'h000C0000)) - 32'sh00060000;
            b.hw = 31'($urandom_range(0, 32'h00040000));
            b.hh = 31'($urandom_range(0, 32'h00040000));
        end else begin
            b.cx = $urandom; b.cy = $urandom;
            b.hw = 31'($urandom); b.hh = 31'($urandom);
        end
        return b;
    endfunction

    // Offer one pair and hold it until the block takes it
    task automatic send_pair(box_t a, box_t b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= DW'({b.ang, b.hh, b.hw, b.cy, b.cx, a.ang, a.hh, a.hw, a.cy, a.cx});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_pair(a, b);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long counted hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready    <= 0;
            hold_cycles <= 0;
            hold_taken  <= 0;
        end else if (hold_req && !hold_taken) begin
            m_tready    <= 0;
            hold_cycles <= 60;
            hold_taken  <= 1;
        end else if (hold_cycles > 0) begin
            m_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Check every result taken at a clock edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_contact('{m_tuser[0], m_tdata[31:0], m_tdata[47:32],
                                   m_tdata[63:48]});
    end

    initial
    begin
        #4000000;
        $display("obb_separating_axis_test_test: errors");
        $finish;
    end

    initial
    begin
        box_t a, b;
        board = new();
        rst_n = 0; s_tvalid = 0; s_tdata = '0;
        send_idle = 0; recv_idle = 0; hold_req = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, degenerate, large overlap, separated, tie
        a = '{0, 0, 31'h10000, 31'h10000, 0};
        send_pair(a, a);                                  // identical, tie on axes
        send_pair(a, '{32'h18000, 0, 31'h10000, 31'h10000, 16'h2000});
        send_pair(a, '{32'h50000, 0, 31'h10000, 31'h10000, 0});   // separated
        send_pair(a, '{32'h20000, 0, 31'h10000, 31'h10000, 0});   // touching
        send_pair('{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0});            // degenerate
        a = '{32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'hFFFF};
        b = '{32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'h0000};
        send_pair(a, b);
        send_pair(b, a);
        send_pair('{0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0},
                  '{0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'h4000}); // largest extents, just below saturation
        for (int q = 0; q < 8; q++)
            send_pair('{0, 0, 31'h20000, 31'h8000, 16'(q * 16'h2000)},
                      '{32'h8000, 32'h4000, 31'h8000, 31'h20000, 16'(q * 16'h1000 + 1)});
        send_pair('{32'hFFFFFFFF, 32'h1, 31'h55555555, 31'h2AAAAAAA, 16'hAAAA},
                  '{32'h1, 32'hFFFFFFFF, 31'h2AAAAAAA, 31'h55555555, 16'h5555});
        drain();

        // Long receiver hold-off while the sender keeps offering: input must stall
        hold_req = 1;
        for (int i = 0; i < 50; i++)
            send_pair(rand_box(), rand_box());
        drain();

        send_idle = 23; recv_idle = 65;
        for (int i = 0; i < 600; i++)
            send_pair(rand_box(), rand_box());
        drain();
        send_idle = 65; recv_idle = 23;
        for (int i = 0; i < 600; i++)
            send_pair(rand_box(), rand_box());
        drain();
        send_idle = 0; recv_idle = 0;
        for (int i = 0; i < 600; i++)
            send_pair(rand_box(), rand_box());
        drain();
        repeat (40) @(posedge clk);

        if (board.errors == 0)
            $display("obb_separating_axis_test_test: clean");
        else
            $display("obb_separating_axis_test_test: errors");
        $finish;
    end

endmodule

/* obb_separating_axis_test.f */
rtl/core/osat_pkg.sv
rtl/core/osat_mulq14.sv
rtl/core/osat_trig.sv
rtl/core/osat_corner.sv
rtl/core/osat_axis_cell.sv
rtl/core/obb_separating_axis_test.sv
tb/obb_separating_axis_test_test.sv
